// ===== rtl/mvpm_pkg.sv =====
package mvpm_pkg;

   localparam int MAX_VOICES = 4;

   localparam int CMD_W     = 3;
   localparam int ID_W      = 16;
   localparam int GAIN_W    = 16;
   localparam int SAMPLE_W  = 16;
   localparam int GAIN_FRAC = 12;
   localparam int PRODUCT_W = SAMPLE_W + GAIN_W;

   localparam int SAMPLES_W = SAMPLE_W * MAX_VOICES;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << GAIN_FRAC);

   localparam logic [CMD_W-1:0] CMD_MIX        = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY       = 3'd1;
   localparam logic [CMD_W-1:0] CMD_STOP       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_VOLUME = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

   localparam logic VOICE_IDLE = 1'b0;
   localparam logic VOICE_LIVE = 1'b1;

   typedef struct packed {
      logic status;
      logic playing;
   } reply_type;

endpackage

// ===== rtl/mvpm_if.sv =====
interface mvpm_req_if;
   logic                                valid;
   logic                                ready;
   logic [mvpm_pkg::CMD_W-1:0]          cmd;
   logic [mvpm_pkg::ID_W-1:0]           sound_id;
   logic [mvpm_pkg::GAIN_W-1:0]         volume;
   logic [mvpm_pkg::SAMPLES_W-1:0]      voice_samples;
   logic [mvpm_pkg::MAX_VOICES-1:0]     voice_ended;

   modport source (
      output valid, cmd, sound_id, volume, voice_samples, voice_ended,
      input  ready
   );
   modport sink (
      input  valid, cmd, sound_id, volume, voice_samples, voice_ended,
      output ready
   );
endinterface

interface mvpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [mvpm_pkg::SAMPLE_W-1:0] mixed_sample;
   logic                                status;
   logic                                sound_playing;

   modport source (
      output valid, mixed_sample, status, sound_playing,
      input  ready
   );
   modport sink (
      input  valid, mixed_sample, status, sound_playing,
      output ready
   );
endinterface

// ===== rtl/multi_voice_pcm_mixer.sv =====
// Lane multiply registers, then truncate-and-sum merge output register.
// Throughput: one item per cycle while the output is not stalled.
// Voice table updates in the transfer cycle, so the next item sees it at once.
// Reset (synchronous, active high): all slots empty and stopped, gains unity,
// pipeline and output emptied.
module multi_voice_pcm_mixer #(
   parameter int VOICES = mvpm_pkg::MAX_VOICES
) (
   input  logic      clock,
   input  logic      reset,
   mvpm_req_if.sink  req_bus,
   mvpm_rsp_if.source rsp_bus
);

   logic                                   req_fire;
   logic                                   s1_load;
   logic                                   s2_load;
   logic                                   s1_valid_ff;
   logic                                   rsp_valid_ff;
   logic [VOICES-1:0]                      lane_enable;
   logic [mvpm_pkg::GAIN_W-1:0]            gain [VOICES];
   logic signed [mvpm_pkg::PRODUCT_W-1:0]  product [VOICES];
   mvpm_pkg::reply_type                    reply;
   mvpm_pkg::reply_type                    reply_s1_ff;
   mvpm_pkg::reply_type                    reply_out;
   logic signed [mvpm_pkg::SAMPLE_W-1:0]   mixed_out;

   // Output register advances when empty or being taken; stage one advances
   // when empty or when it can drain into the output register.
   assign s2_load       = !rsp_valid_ff || rsp_bus.ready;
   assign s1_load       = !s1_valid_ff || s2_load;
   assign req_bus.ready = s1_load;
   assign req_fire      = req_bus.valid && s1_load;

   mvpm_voice_table #(.VOICES(VOICES)) u_table (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .cmd         (req_bus.cmd),
      .sound_id    (req_bus.sound_id),
      .volume      (req_bus.volume),
      .voice_ended (req_bus.voice_ended[VOICES-1:0]),
      .lane_enable (lane_enable),
      .gain        (gain),
      .reply       (reply)
   );

   // one multiplier per voice
   for (genvar g = 0; g < VOICES; g++) begin : g_lane
      mvpm_lane u_lane (
         .clock      (clock),
         .load       (s1_load),
         .enable     (lane_enable[g]),
         .sample     ($signed(req_bus.voice_samples[g*mvpm_pkg::SAMPLE_W +: mvpm_pkg::SAMPLE_W])),
         .gain       (gain[g]),
         .product_ff (product[g])
      );
   end

   // hold the status and query answer alongside the lane products
   always_ff @(posedge clock) begin
      if (s1_load) reply_s1_ff <= reply;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) s1_valid_ff  <= req_fire;
         if (s2_load) rsp_valid_ff <= s1_valid_ff;
      end
   end

   mvpm_merge #(.VOICES(VOICES)) u_merge (
      .clock    (clock),
      .load     (s2_load && s1_valid_ff),
      .product  (product),
      .reply    (reply_s1_ff),
      .mixed_ff (mixed_out),
      .reply_ff (reply_out)
   );

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.mixed_sample  = mixed_out;
   assign rsp_bus.status        = reply_out.status;
   assign rsp_bus.sound_playing = reply_out.playing;

   // a failed play is never a mix or a query
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && reply_out.status |-> (mixed_out == '0) && !reply_out.playing)
      else $error("status set together with other result fields");

   // every transfer in lands in stage one
   a_fire_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("transfer lost before stage one");

   // the output only fills from an occupied stage one
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result appeared without an item in stage one");

   // a stalled output freezes stage one when stage one is occupied
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready && s1_valid_ff |-> !req_bus.ready)
      else $error("input taken while both stages are full and stalled");

endmodule

// ===== rtl/mvpm_voice_table.sv =====
module mvpm_voice_table #(
   parameter int VOICES = mvpm_pkg::MAX_VOICES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               fire,
   input  logic [mvpm_pkg::CMD_W-1:0]         cmd,
   input  logic [mvpm_pkg::ID_W-1:0]          sound_id,
   input  logic [mvpm_pkg::GAIN_W-1:0]        volume,
   input  logic [VOICES-1:0]                  voice_ended,
   output logic [VOICES-1:0]                  lane_enable,
   output logic [mvpm_pkg::GAIN_W-1:0]        gain [VOICES],
   output mvpm_pkg::reply_type                reply
);

   logic [mvpm_pkg::ID_W-1:0]   sound_ff [VOICES];
   logic [mvpm_pkg::ID_W-1:0]   sound_in [VOICES];
   logic [mvpm_pkg::GAIN_W-1:0] gain_ff  [VOICES];
   logic [mvpm_pkg::GAIN_W-1:0] gain_in  [VOICES];
   logic [VOICES-1:0]           active_ff;
   logic [VOICES-1:0]           active_in;

   logic [VOICES-1:0] match;
   logic [VOICES-1:0] match_first;
   logic [VOICES-1:0] stopped;
   logic [VOICES-1:0] stopped_first;
   logic [VOICES-1:0] play_sel;

   // id zero never matches a slot
   always_comb begin
      for (int i = 0; i < VOICES; i++) begin
         match[i] = (sound_id != '0) && (sound_ff[i] == sound_id);
      end
   end

   // lowest set bit, one-hot
   assign match_first   = match & (~match + VOICES'(1));
   assign stopped       = ~active_ff;
   assign stopped_first = stopped & (~stopped + VOICES'(1));
   assign play_sel      = (|match) ? match_first : stopped_first;

   always_comb begin
      sound_in    = sound_ff;
      gain_in     = gain_ff;
      active_in   = active_ff;
      lane_enable = '0;
      reply       = '0;
      unique case (cmd)
         mvpm_pkg::CMD_MIX: begin
            lane_enable = active_ff & ~voice_ended;
            for (int i = 0; i < VOICES; i++) begin
               if (active_ff[i] && voice_ended[i]) begin
                  active_in[i] = mvpm_pkg::VOICE_IDLE;
                  sound_in[i]  = '0;
               end
            end
         end
         mvpm_pkg::CMD_PLAY: begin
            if (stopped == '0) begin
               reply.status = 1'b1;
            end else begin
               for (int i = 0; i < VOICES; i++) begin
                  if (play_sel[i]) begin
                     sound_in[i]  = sound_id;
                     active_in[i] = mvpm_pkg::VOICE_LIVE;
                  end
               end
            end
         end
         mvpm_pkg::CMD_STOP: begin
            for (int i = 0; i < VOICES; i++) begin
               if (match_first[i]) active_in[i] = mvpm_pkg::VOICE_IDLE;
            end
         end
         mvpm_pkg::CMD_SET_VOLUME: begin
            for (int i = 0; i < VOICES; i++) begin
               if (match_first[i]) gain_in[i] = volume;
            end
         end
         mvpm_pkg::CMD_QUERY: begin
            reply.playing = |(match_first & active_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < VOICES; i++) begin
            sound_ff[i] <= '0;
            gain_ff[i]  <= mvpm_pkg::UNITY_GAIN;
         end
      end else if (fire) begin
         active_ff <= active_in;
         sound_ff  <= sound_in;
         gain_ff   <= gain_in;
      end
   end

   assign gain = gain_ff;

endmodule

// ===== rtl/mvpm_lane.sv =====
module mvpm_lane (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic                                   enable,
   input  logic signed [mvpm_pkg::SAMPLE_W-1:0]   sample,
   input  logic [mvpm_pkg::GAIN_W-1:0]            gain,
   output logic signed [mvpm_pkg::PRODUCT_W-1:0]  product_ff
);

   logic signed [mvpm_pkg::PRODUCT_W:0]   product_wide;
   logic signed [mvpm_pkg::PRODUCT_W-1:0] product_in;

   // signed sample times unsigned gain; the exact product fits 32 bits
   assign product_wide = sample * $signed({1'b0, gain});
   assign product_in   = enable ? product_wide[mvpm_pkg::PRODUCT_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (load) product_ff <= product_in;
   end

endmodule

// ===== rtl/mvpm_merge.sv =====
module mvpm_merge #(
   parameter int VOICES = mvpm_pkg::MAX_VOICES
) (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic signed [mvpm_pkg::PRODUCT_W-1:0]  product [VOICES],
   input  mvpm_pkg::reply_type                    reply,
   output logic signed [mvpm_pkg::SAMPLE_W-1:0]   mixed_ff,
   output mvpm_pkg::reply_type                    reply_ff
);

   localparam logic signed [mvpm_pkg::PRODUCT_W-1:0] ROUND_BIAS =
      mvpm_pkg::PRODUCT_W'((1 << mvpm_pkg::GAIN_FRAC) - 1);

   logic [mvpm_pkg::SAMPLE_W-1:0] mixed_in;

   // bias negative products so the shift truncates toward zero; sum wraps
   always_comb begin
      logic signed [mvpm_pkg::PRODUCT_W-1:0] biased;
      mixed_in = '0;
      for (int i = 0; i < VOICES; i++) begin
         biased   = product[i] + (product[i][mvpm_pkg::PRODUCT_W-1] ? ROUND_BIAS : '0);
         mixed_in = mixed_in + biased[mvpm_pkg::GAIN_FRAC +: mvpm_pkg::SAMPLE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mixed_ff <= $signed(mixed_in);
         reply_ff <= reply;
      end
   end

endmodule
